// ===== hdl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cursor control block.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // field widths of the cursor position and of a character byte
  localparam int ColW  = 7;
  localparam int RowW  = 5;
  localparam int CharW = 8;
  localparam int AttrW = 8;

  // default screen size
  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  // control codes
  localparam logic [CharW-1:0] CodeBackspace      = 8'd8;
  localparam logic [CharW-1:0] CodeLineFeed       = 8'd10;
  localparam logic [CharW-1:0] CodeCarriageReturn = 8'd13;
  localparam logic [CharW-1:0] GlyphSpace         = 8'd32;

  // attribute after reset
  localparam logic [AttrW-1:0] AttrReset = 8'h0F;

  // one result transaction
  typedef struct packed {
    logic             write_valid;
    logic [ColW-1:0]  write_column;
    logic [RowW-1:0]  write_row;
    logic [CharW-1:0] write_glyph;
    logic [AttrW-1:0] write_colour;
    logic             scroll_request;
    logic [ColW-1:0]  cursor_column;
    logic [RowW-1:0]  cursor_row;
  } result_t;

endpackage

// ===== hdl/tcc_in_reg.sv =====
// ----------------------------------------------------------------------------
// tcc_in_reg
// Input register for the character channel; holds one transaction until the
// cursor stage takes it.
// ----------------------------------------------------------------------------
module tcc_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tcc_pkg::CharW-1:0] char_code_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [tcc_pkg::CharW-1:0] char_code_o
);

  logic                      valid_q, valid_d;
  logic [tcc_pkg::CharW-1:0] code_q;
  logic                      load;

  // accept when empty or when the held transaction moves on
  assign in_ready_o = !valid_q || ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= char_code_i;
    end
  end

  assign valid_o     = valid_q;
  assign char_code_o = code_q;

endmodule

// ===== hdl/tcc_cursor.sv =====
// ----------------------------------------------------------------------------
// tcc_cursor
// Cursor position, attribute register and result register. Decodes one
// character per cycle while the result register can take it, and updates the cursor as the result is registered.
// ----------------------------------------------------------------------------
module tcc_cursor #(
  parameter int Columns = tcc_pkg::DefColumns,
  parameter int Rows    = tcc_pkg::DefRows
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tcc_pkg::AttrW-1:0] cfg_wdata_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [tcc_pkg::CharW-1:0] char_code_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tcc_pkg::result_t          result_o
);

  localparam logic [tcc_pkg::ColW-1:0] LastCol = tcc_pkg::ColW'(Columns - 1);
  localparam logic [tcc_pkg::RowW-1:0] LastRow = tcc_pkg::RowW'(Rows - 1);

  logic [tcc_pkg::ColW-1:0]  col_q, col_d;
  logic [tcc_pkg::RowW-1:0]  row_q, row_d;
  logic [tcc_pkg::AttrW-1:0] attr_q;
  logic                      out_valid_q, out_valid_d;
  tcc_pkg::result_t          res_q, res_d;
  logic                      advance;
  logic                      last_row;

  // the result register frees up when empty or taken
  assign ready_o = !out_valid_q || out_ready_i;
  assign advance = valid_i && ready_o;

  assign last_row = (row_q >= LastRow);

  // character decode and next cursor position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    res_d = '0;
    unique case (char_code_i)
      tcc_pkg::CodeBackspace: begin
        if (col_q == '0) begin
          if (row_q != '0) begin
            row_d = row_q - 1'b1;
          end
        end else begin
          col_d = col_q - 1'b1;
        end
        res_d.write_valid  = 1'b1;
        res_d.write_column = col_d;
        res_d.write_row    = row_d;
        res_d.write_glyph  = tcc_pkg::GlyphSpace;
        res_d.write_colour = attr_q;
      end
      tcc_pkg::CodeLineFeed: begin
        if (last_row) begin
          res_d.scroll_request = 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      tcc_pkg::CodeCarriageReturn: begin
        col_d = '0;
      end
      default: begin
        res_d.write_valid  = 1'b1;
        res_d.write_column = col_q;
        res_d.write_row    = row_q;
        res_d.write_glyph  = char_code_i;
        res_d.write_colour = attr_q;
        if (col_q >= LastCol) begin
          col_d = '0;
          if (last_row) begin
            res_d.scroll_request = 1'b1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    endcase
    res_d.cursor_column = col_d;
    res_d.cursor_row    = row_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // cursor state, attribute and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= tcc_pkg::AttrReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (advance) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// ===== hdl/text_console_cursor_control_top.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_control_top
// Cursor control for a text screen: one character in, at most one cell
// write and the cursor update out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o carries one character byte per
//   transaction. Output channel out_valid_o / out_ready_i carries one result
//   per character: the cell written (if any), a scroll request and the
//   cursor position after the character.
//   The attribute register is written through cfg_we_i / cfg_wdata_i;
//   write it only while no transaction is in flight.
//   A character accepted at the input is held in the input register and
//   goes through the decode into the result register once that register
//   is free; a stalled receiver keeps it in the input register.
//   Throughput is one character per cycle while the receiver takes every
//   result.
//   Reset puts the cursor at column 0, row 0, sets the attribute to 0x0F
//   and empties both registers.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_ready_o then drops until the result is taken.
// ----------------------------------------------------------------------------
module text_console_cursor_control_top #(
  parameter int Columns = tcc_pkg::DefColumns,
  parameter int Rows    = tcc_pkg::DefRows
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tcc_pkg::AttrW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tcc_pkg::CharW-1:0] char_code_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      write_valid_o,
  output logic [tcc_pkg::ColW-1:0]  write_column_o,
  output logic [tcc_pkg::RowW-1:0]  write_row_o,
  output logic [tcc_pkg::CharW-1:0] write_glyph_o,
  output logic [tcc_pkg::AttrW-1:0] write_colour_o,
  output logic                      scroll_request_o,
  output logic [tcc_pkg::ColW-1:0]  cursor_column_o,
  output logic [tcc_pkg::RowW-1:0]  cursor_row_o
);

  logic                      stg_valid;
  logic                      stg_ready;
  logic [tcc_pkg::CharW-1:0] stg_code;
  tcc_pkg::result_t          result;

  // input register
  tcc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .valid_o     (stg_valid),
    .ready_i     (stg_ready),
    .char_code_o (stg_code)
  );

  // decode, cursor state and result register
  tcc_cursor #(
    .Columns (Columns),
    .Rows    (Rows)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (stg_valid),
    .ready_o     (stg_ready),
    .char_code_i (stg_code),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  // result fields
  assign write_valid_o    = result.write_valid;
  assign write_column_o   = result.write_column;
  assign write_row_o      = result.write_row;
  assign write_glyph_o    = result.write_glyph;
  assign write_colour_o   = result.write_colour;
  assign scroll_request_o = result.scroll_request;
  assign cursor_column_o  = result.cursor_column;
  assign cursor_row_o     = result.cursor_row;

  // a scroll leaves the cursor on the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scroll_request_o |-> cursor_row_o == tcc_pkg::RowW'(Rows - 1))
    else $error("scroll request with cursor off the last row");

  // cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_column_o < tcc_pkg::ColW'(Columns - 1)
                     || cursor_column_o == tcc_pkg::ColW'(Columns - 1))
                    && (cursor_row_o < tcc_pkg::RowW'(Rows - 1)
                     || cursor_row_o == tcc_pkg::RowW'(Rows - 1)))
    else $error("cursor outside the screen");

  // a result with no cell write carries zero write fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_column_o == '0 && write_row_o == '0
                                      && write_glyph_o == '0 && write_colour_o == '0)
    else $error("write fields set without a cell write");

endmodule

// ===== tb/sv/tb_text_console_cursor_control_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_control_top
// Self-checking bench for the text console cursor control block. A cursor
// tracker follows every accepted character and predicts the cell write,
// scroll request and new cursor position. Each result transaction is
// compared field by field with the oldest prediction. Directed walks reach
// the home corner, the last row and the wrap on the last row. Random
// character streams follow under several attribute settings, with random
// gaps and stalls on both channels in most settings.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_control_top;

  localparam int Columns   = tcc_pkg::DefColumns;
  localparam int Rows      = tcc_pkg::DefRows;
  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 180;

  // clock, reset and block ports
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [tcc_pkg::AttrW-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [tcc_pkg::CharW-1:0] char_code_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      write_valid_o;
  logic [tcc_pkg::ColW-1:0]  write_column_o;
  logic [tcc_pkg::RowW-1:0]  write_row_o;
  logic [tcc_pkg::CharW-1:0] write_glyph_o;
  logic [tcc_pkg::AttrW-1:0] write_colour_o;
  logic                      scroll_request_o;
  logic [tcc_pkg::ColW-1:0]  cursor_column_o;
  logic [tcc_pkg::RowW-1:0]  cursor_row_o;

  // cursor tracker state and pending cursor updates
  logic [tcc_pkg::ColW-1:0]  track_col;
  logic [tcc_pkg::RowW-1:0]  track_row;
  logic [tcc_pkg::AttrW-1:0] track_attr;
  tcc_pkg::result_t          cursor_updates_q[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  in_idle_on  = 1'b1;
  bit  out_idle_on = 1'b1;
  int  stall_left  = 0;

  text_console_cursor_control_top #(
    .Columns(Columns),
    .Rows   (Rows)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_valid_o   (write_valid_o),
    .write_column_o  (write_column_o),
    .write_row_o     (write_row_o),
    .write_glyph_o   (write_glyph_o),
    .write_colour_o  (write_colour_o),
    .scroll_request_o(scroll_request_o),
    .cursor_column_o (cursor_column_o),
    .cursor_row_o    (cursor_row_o)
  );

  // clock generation
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(4, 20);
  endfunction

  function automatic logic [tcc_pkg::CharW-1:0] random_printable();
    logic [tcc_pkg::CharW-1:0] c;
    do c = tcc_pkg::CharW'($urandom_range(0, 255));
    while (c == tcc_pkg::CodeBackspace || c == tcc_pkg::CodeLineFeed
           || c == tcc_pkg::CodeCarriageReturn);
    return c;
  endfunction

  // random character with a tunable share of backspaces
  function automatic logic [tcc_pkg::CharW-1:0] random_code(input int bs_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < bs_pct) return tcc_pkg::CodeBackspace;
    else if (r < bs_pct + 12) return tcc_pkg::CodeLineFeed;
    else if (r < bs_pct + 15) return tcc_pkg::CodeCarriageReturn;
    else return tcc_pkg::CharW'($urandom_range(0, 255));
  endfunction

  // cursor tracker: effect of one character, advances the tracked cursor
  function automatic tcc_pkg::result_t next_cursor_update(
    input logic [tcc_pkg::CharW-1:0] code);
    tcc_pkg::result_t upd;
    logic             on_last_row;
    upd = '0;
    on_last_row = (int'(track_row) >= Rows - 1);
    if (code == tcc_pkg::CodeBackspace) begin
      if (track_col == '0) begin
        if (track_row != '0) track_row = track_row - 1'b1;
      end else begin
        track_col = track_col - 1'b1;
      end
      upd.write_valid  = 1'b1;
      upd.write_column = track_col;
      upd.write_row    = track_row;
      upd.write_glyph  = tcc_pkg::GlyphSpace;
      upd.write_colour = track_attr;
    end else if (code == tcc_pkg::CodeLineFeed) begin
      if (on_last_row) upd.scroll_request = 1'b1;
      else track_row = track_row + 1'b1;
    end else if (code == tcc_pkg::CodeCarriageReturn) begin
      track_col = '0;
    end else begin
      upd.write_valid  = 1'b1;
      upd.write_column = track_col;
      upd.write_row    = track_row;
      upd.write_glyph  = code;
      upd.write_colour = track_attr;
      if (int'(track_col) >= Columns - 1) begin
        track_col = '0;
        if (on_last_row) upd.scroll_request = 1'b1;
        else track_row = track_row + 1'b1;
      end else begin
        track_col = track_col + 1'b1;
      end
    end
    upd.cursor_column = track_col;
    upd.cursor_row    = track_row;
    return upd;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // send one character transaction, then an optional gap
  task automatic send_char(input logic [tcc_pkg::CharW-1:0] code);
    int gap;
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i);
    while (!in_ready_o);
    cursor_updates_q.push_back(next_cursor_update(code));
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and let every pending result drain
  task automatic finish_traffic();
    in_valid_i <= 1'b0;
    while (cursor_updates_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_attr(input logic [tcc_pkg::AttrW-1:0] attr);
    finish_traffic();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= attr;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    track_attr = attr;
  endtask

  // receiver: random stalls, result check
  always @(posedge clk_i) begin
    tcc_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cursor_updates_q.size() == 0) begin
        report_error("result transaction with no pending cursor update");
      end else begin
        want = cursor_updates_q.pop_front();
        check_field("write_valid", 8'(write_valid_o), 8'(want.write_valid));
        check_field("write_column", 8'(write_column_o), 8'(want.write_column));
        check_field("write_row", 8'(write_row_o), 8'(want.write_row));
        check_field("write_glyph", write_glyph_o, want.write_glyph);
        check_field("write_colour", write_colour_o, want.write_colour);
        check_field("scroll_request", 8'(scroll_request_o), 8'(want.scroll_request));
        check_field("cursor_column", 8'(cursor_column_o), 8'(want.cursor_column));
        check_field("cursor_row", 8'(cursor_row_o), 8'(want.cursor_row));
      end
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (out_idle_on) stall_left = pick_gap();
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("text_console_cursor_control_top test failed");
      $finish;
    end
  end

  // home corner, reset attribute, control codes and code extremes
  task automatic test_home_and_codes();
    send_char(tcc_pkg::CodeBackspace);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(tcc_pkg::CodeBackspace);
    send_char(tcc_pkg::CodeCarriageReturn);
    send_char(tcc_pkg::CodeLineFeed);
    send_char(tcc_pkg::CodeBackspace);
    send_char(tcc_pkg::CodeLineFeed);
    send_char(tcc_pkg::GlyphSpace);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(tcc_pkg::CodeCarriageReturn);
    send_char(tcc_pkg::CodeBackspace);
  endtask

  // line feeds down to the last row, where they scroll
  task automatic test_last_row_feed();
    set_attr(8'h00);
    while (int'(track_row) < Rows - 1) send_char(tcc_pkg::CodeLineFeed);
    send_char(tcc_pkg::CodeLineFeed);
    send_char(tcc_pkg::CodeLineFeed);
  endtask

  // fill the last row until it wraps and scrolls, then back up a row
  task automatic test_wrap_last_row();
    set_attr(8'hFF);
    send_char(tcc_pkg::CodeCarriageReturn);
    repeat (Columns) send_char(random_printable());
    send_char(tcc_pkg::CodeBackspace);
    send_char(tcc_pkg::CodeBackspace);
  endtask

  // random character streams under several attributes
  task automatic test_random_stream();
    logic [tcc_pkg::AttrW-1:0] attrs[5];
    int sent;
    int run;
    attrs = '{8'h5A, 8'hA5, tcc_pkg::AttrW'($urandom_range(0, 255)), 8'hFF, 8'h00};
    for (int p = 0; p < 5; p++) begin
      set_attr(attrs[p]);
      in_idle_on  = (p != 2);
      out_idle_on = (p != 2) && (p != 4);
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 19) == 0) begin
          // long printable run to reach the wrap
          run = $urandom_range(40, 100);
          repeat (run) send_char(random_printable());
          sent += run;
        end else begin
          send_char(random_code(p == 3 ? 40 : 8));
          sent++;
        end
      end
    end
  endtask

  // test sequence
  initial begin
    track_col  = '0;
    track_row  = '0;
    track_attr = tcc_pkg::AttrReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_home_and_codes();
    test_last_row_feed();
    test_wrap_last_row();
    test_random_stream();
    finish_traffic();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("text_console_cursor_control_top test passed");
    end else begin
      $display("text_console_cursor_control_top test failed");
    end
    $finish;
  end

endmodule

// ===== text_console_cursor_control_top.f =====
hdl/tcc_pkg.sv
hdl/tcc_in_reg.sv
hdl/tcc_cursor.sv
hdl/text_console_cursor_control_top.sv
tb/sv/tb_text_console_cursor_control_top.sv
